/* rtl/modexp_pkg.sv */
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared types for the modular exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

   // status of the bit-serial modular multiplier
   typedef struct packed {
      logic busy;
      logic done;
   } mul_stat_type;

endpackage

/* rtl/modexp_mulmod.sv */
// ----------------------------------------------------------------------------
// modexp_mulmod
// Bit-serial interleaved modular multiplier: product = a * b mod m, with
// a <= m and m > 0, one bit of b per cycle from the most significant.
// ----------------------------------------------------------------------------
module modexp_mulmod #(
   parameter int VALUE_BITS = 31
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [VALUE_BITS-1:0]        op_a,
   input  logic [VALUE_BITS-1:0]        op_b,
   input  logic [VALUE_BITS-1:0]        op_m,
   output modexp_pkg::mul_stat_type     stat,
   output logic [VALUE_BITS-1:0]        product
);
   import modexp_pkg::*;

   localparam int CNT_W = $clog2(VALUE_BITS);

   logic [VALUE_BITS-1:0] a_ff;
   logic [VALUE_BITS-1:0] b_ff;
   logic [VALUE_BITS-1:0] m_ff;
   logic [VALUE_BITS-1:0] r_ff;
   logic [VALUE_BITS-1:0] r_in;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;

   logic [VALUE_BITS:0] dbl;
   logic [VALUE_BITS:0] dbl_red;
   logic [VALUE_BITS:0] sum;
   logic [VALUE_BITS:0] sum_red;
   logic [VALUE_BITS:0] m_ext;
   logic [VALUE_BITS:0] addend;

   // r stays below m: double and fold, then add and fold
   always_comb begin
      m_ext   = {1'b0, m_ff};
      dbl     = {r_ff, 1'b0};
      dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
      addend  = b_ff[VALUE_BITS-1] ? {1'b0, a_ff} : '0;
      sum     = dbl_red + addend;
      sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
      r_in    = sum_red[VALUE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(VALUE_BITS - 1);
            a_ff    <= op_a;
            b_ff    <= op_b;
            m_ff    <= op_m;
            r_ff    <= '0;
         end else if (busy_ff) begin
            r_ff <= r_in;
            b_ff <= {b_ff[VALUE_BITS-2:0], 1'b0};
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign product   = r_ff;

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("multiplier done while busy");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("multiplier done held longer than one cycle");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && m_ff != '0 && a_ff <= m_ff) |-> (r_ff < m_ff))
      else $error("partial remainder not below modulus");

endmodule

/* rtl/modular_exponentiation_top.sv */
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// Right-to-left square-and-multiply: base ^ exponent mod modulus.
// ----------------------------------------------------------------------------
// one shared bit-serial multiplier does every reduction
// one item at a time: req_stall is high from accept until the result is queued
// zero exponent or zero modulus skips the multiplier and goes straight to ST_FINISH
// reset (synchronous) clears the sequencer and the output valid
module modular_exponentiation_top #(
   parameter int VALUE_BITS = 31,
   parameter int EXP_BITS   = 63
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_base,
   input  logic [EXP_BITS-1:0]   req_exponent,
   input  logic [VALUE_BITS-1:0] req_modulus,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VALUE_BITS-1:0] rsp_power_result
);
   import modexp_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_STEP,
      ST_ACC,
      ST_SQ,
      ST_FINISH
   } state_type;

   state_type             state_ff;
   logic [EXP_BITS-1:0]   exp_ff;
   logic [VALUE_BITS-1:0] mod_ff;
   logic [VALUE_BITS-1:0] acc_ff;
   logic [VALUE_BITS-1:0] sq_ff;
   logic [VALUE_BITS-1:0] result_ff;
   logic                  rsp_valid_ff;
   logic [VALUE_BITS-1:0] rsp_result_ff;

   logic                  mul_start_ff;
   logic [VALUE_BITS-1:0] mul_a_ff;
   logic [VALUE_BITS-1:0] mul_b_ff;
   mul_stat_type          mul_stat;
   logic [VALUE_BITS-1:0] mul_product;

   modexp_mulmod #(
      .VALUE_BITS(VALUE_BITS)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .op_a    (mul_a_ff),
      .op_b    (mul_b_ff),
      .op_m    (mod_ff),
      .stat    (mul_stat),
      .product (mul_product)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mul_start_ff <= 1'b0;
      end else begin
         mul_start_ff <= 1'b0;
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  exp_ff <= req_exponent;
                  mod_ff <= req_modulus;
                  if (req_exponent == '0) begin
                     result_ff <= VALUE_BITS'(1);
                     state_ff  <= ST_FINISH;
                  end else if (req_modulus == '0) begin
                     result_ff <= '0;
                     state_ff  <= ST_FINISH;
                  end else begin
                     // bring the base below the modulus as 1 * base
                     mul_a_ff     <= VALUE_BITS'(1);
                     mul_b_ff     <= req_base;
                     mul_start_ff <= 1'b1;
                     state_ff     <= ST_REDUCE;
                  end
               end
            end
            ST_REDUCE: begin
               if (mul_stat.done) begin
                  sq_ff    <= mul_product;
                  acc_ff   <= VALUE_BITS'(1);
                  state_ff <= ST_STEP;
               end
            end
            ST_STEP: begin
               if (exp_ff == '0) begin
                  result_ff <= acc_ff;
                  state_ff  <= ST_FINISH;
               end else if (exp_ff[0]) begin
                  mul_a_ff     <= sq_ff;
                  mul_b_ff     <= acc_ff;
                  mul_start_ff <= 1'b1;
                  state_ff     <= ST_ACC;
               end else begin
                  mul_a_ff     <= sq_ff;
                  mul_b_ff     <= sq_ff;
                  mul_start_ff <= 1'b1;
                  state_ff     <= ST_SQ;
               end
            end
            ST_ACC: begin
               if (mul_stat.done) begin
                  acc_ff       <= mul_product;
                  mul_a_ff     <= sq_ff;
                  mul_b_ff     <= sq_ff;
                  mul_start_ff <= 1'b1;
                  state_ff     <= ST_SQ;
               end
            end
            ST_SQ: begin
               if (mul_stat.done) begin
                  sq_ff    <= mul_product;
                  exp_ff   <= exp_ff >> 1;
                  state_ff <= ST_STEP;
               end
            end
            ST_FINISH: begin
               // wait for the output register to free up
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_result_ff <= result_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_result_ff;

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      mul_start_ff |-> !mul_stat.busy)
      else $error("multiplier started while busy");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_stat.done |-> (state_ff == ST_REDUCE || state_ff == ST_ACC ||
                         state_ff == ST_SQ))
      else $error("multiplier result arrived outside a wait state");

   a_mod_nonzero: assert property (@(posedge clock) disable iff (reset)
      (mul_start_ff || mul_stat.busy) |-> (mod_ff != '0))
      else $error("multiplier running with zero modulus");

   a_reset_clear: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid_ff)
      else $error("output valid set right after reset");

endmodule
